// ----- src/gc_pkg.sv -----
// Shared constants for the greedy graph coloring block.
`default_nettype none

package gc_pkg;

  // Fixed field widths of the streaming ports
  localparam int unsigned VERTEX_W = 10;
  localparam int unsigned COLOR_W  = 6;

  // Default sizing of the color store and the used-color bitmap
  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned MAX_COLORS_DEF   = 64;

endpackage : gc_pkg

`default_nettype wire

// ----- src/gc_color_mem.sv -----
// Color store: one write port, one registered read port.
`default_nettype none

module gc_color_mem #(
  parameter int unsigned DEPTH = gc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned AW    = $clog2(gc_pkg::MAX_VERTICES_DEF),
  parameter int unsigned DW    = $clog2(gc_pkg::MAX_COLORS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read-before-write: a same-edge write is not seen here
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : gc_color_mem

`default_nettype wire

// ----- src/gc_first_free.sv -----
// Priority encoder: lowest clear bit of the used-color bitmap.
`default_nettype none

module gc_first_free #(
  parameter int unsigned N = gc_pkg::MAX_COLORS_DEF,
  parameter int unsigned W = $clog2(gc_pkg::MAX_COLORS_DEF)
) (
  input  wire logic [N-1:0] used,
  output logic              found,
  output logic      [W-1:0] color
);

  always_comb begin
    found = 1'b0;
    color = '0;
    // scan downward so the lowest free index wins
    for (int k = N - 1; k >= 0; k--) begin
      if (!used[k]) begin
        found = 1'b1;
        color = W'(k);
      end
    end
  end

endmodule : gc_first_free

`default_nettype wire

// ----- src/greedy_graph_coloring.sv -----
// Top level of the streaming first-fit greedy graph coloring block.
//
// Usage:
//   in_ channel: one adjacency entry per transaction. in_has_neighbor=0 is an
//   empty-list marker, in_last_of_vertex closes the current vertex, and
//   in_first_of_graph restarts the vertex count, bitmap and running maximum.
//   out_ channel: one transaction per closed vertex carrying the vertex index,
//   its color, the running maximum color and an overflow flag (all colors
//   taken by neighbors, color forced to 0).
//   Throughput: one entry per cycle while in_ready is high, set by the
//   single color-store read port and the mark/select stage behind it.
//   The result of a closing entry reaches out_ through the color-store read
//   register and then the result register.
//   A write to the store is forwarded to an entry read at the same edge.
//   Reset clears the vertex counter, bitmap, maximum and all valid flags; the
//   color store is not cleared and needs no clearing pass.
//   If the receiver stalls, the pending result holds and the block keeps
//   taking non-closing entries; a closing entry then waits in the mark stage
//   with in_ready low until the result register frees.
`default_nettype none

module greedy_graph_coloring #(
  parameter int unsigned MAX_VERTICES = gc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_COLORS   = gc_pkg::MAX_COLORS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // adjacency entries
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [gc_pkg::VERTEX_W-1:0]  in_neighbor,
  input  wire logic                         in_has_neighbor,
  input  wire logic                         in_last_of_vertex,
  input  wire logic                         in_first_of_graph,
  // colored vertices
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [gc_pkg::VERTEX_W-1:0]  out_vertex,
  output logic      [gc_pkg::COLOR_W-1:0]   out_vertex_color,
  output logic      [gc_pkg::COLOR_W-1:0]   out_max_color,
  output logic                              out_overflow
);

  localparam int unsigned VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CLW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  // common compare width for neighbor index vs vertex counter
  localparam int unsigned CW  = (VW > gc_pkg::VERTEX_W) ? VW : gc_pkg::VERTEX_W;
  // common width for color truncation to the port
  localparam int unsigned KW  = (CLW > gc_pkg::COLOR_W) ? CLW : gc_pkg::COLOR_W;

  // ---------------------------------------------------------------
  // Entry side: vertex counter and eligibility of the neighbor
  // ---------------------------------------------------------------
  logic           in_acc;
  logic [VW-1:0]  cur_r, cur_nxt;
  logic [VW-1:0]  cur_eff;
  logic [CW-1:0]  nb_cw;
  logic           elig;
  logic [VW-1:0]  rd_addr;

  // Mark stage registers
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_first_r;
  logic             s1_last_r;
  logic             s1_elig_r;
  logic [VW-1:0]    s1_vertex_r;
  logic             s1_fwd_hit_r;
  logic [CLW-1:0]   s1_fwd_color_r;
  logic             s1_adv;

  // Per-graph state
  logic [MAX_COLORS-1:0] bitmap_r, bitmap_nxt;
  logic [CLW-1:0]        highest_r, highest_nxt;

  // Mark / select datapath
  logic [CLW-1:0]        rd_data;
  logic [CLW-1:0]        nbr_color;
  logic [MAX_COLORS-1:0] bitmap_base;
  logic [MAX_COLORS-1:0] used;
  logic                  found;
  logic [CLW-1:0]        pick;
  logic [CLW-1:0]        highest_base;
  logic                  wr_en;
  logic                  fwd_hit;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  logic [gc_pkg::VERTEX_W-1:0]  out_vertex_r;
  logic [gc_pkg::COLOR_W-1:0]   out_color_r;
  logic [gc_pkg::COLOR_W-1:0]   out_max_r;
  logic                         out_ovf_r;
  logic [CW-1:0]                vertex_cw;
  logic [KW-1:0]                pick_kw;
  logic [KW-1:0]                highest_kw;

  // A closing entry only moves on when the result register can take it
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign cur_eff = in_first_of_graph ? '0 : cur_r;
  assign nb_cw   = CW'(in_neighbor);
  // nb below the counter is also below MAX_VERTICES
  assign elig    = in_has_neighbor && (nb_cw < CW'(cur_eff));
  assign rd_addr = nb_cw[VW-1:0];

  always_comb begin
    cur_nxt = cur_r;
    if (in_acc) begin
      if (in_last_of_vertex) begin
        cur_nxt = (cur_eff == VW'(MAX_VERTICES - 1)) ? '0 : cur_eff + 1'b1;
      end else begin
        cur_nxt = cur_eff;
      end
    end
  end

  // store write from the mark stage at the same edge as this entry's read
  assign wr_en   = s1_adv && s1_last_r;
  assign fwd_hit = wr_en && (s1_vertex_r == rd_addr);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cur_r      <= cur_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_first_r     <= in_first_of_graph;
      s1_last_r      <= in_last_of_vertex;
      s1_elig_r      <= elig;
      s1_vertex_r    <= cur_eff;
      s1_fwd_hit_r   <= fwd_hit;
      s1_fwd_color_r <= pick;
    end
  end

  gc_color_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (VW),
    .DW    (CLW)
  ) u_color_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_vertex_r),
    .wr_data (pick)
  );

  // ---------------------------------------------------------------
  // Mark stage: OR in the neighbor's color, pick the first free one
  // ---------------------------------------------------------------
  assign nbr_color    = s1_fwd_hit_r ? s1_fwd_color_r : rd_data;
  assign bitmap_base  = s1_first_r ? '0 : bitmap_r;
  assign used         = s1_elig_r ? (bitmap_base | (MAX_COLORS'(1) << nbr_color))
                                  : bitmap_base;
  assign highest_base = s1_first_r ? '0 : highest_r;

  gc_first_free #(
    .N (MAX_COLORS),
    .W (CLW)
  ) u_first_free (
    .used  (used),
    .found (found),
    .color (pick)
  );

  always_comb begin
    bitmap_nxt  = bitmap_r;
    highest_nxt = highest_r;
    if (s1_adv) begin
      bitmap_nxt  = s1_last_r ? '0 : used;
      highest_nxt = (s1_last_r && found && (pick > highest_base)) ? pick : highest_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r  <= '0;
      highest_r <= '0;
    end else begin
      bitmap_r  <= bitmap_nxt;
      highest_r <= highest_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  assign vertex_cw  = CW'(s1_vertex_r);
  assign pick_kw    = KW'(pick);
  assign highest_kw = KW'(highest_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wr_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_vertex_r <= vertex_cw[gc_pkg::VERTEX_W-1:0];
      out_color_r  <= pick_kw[gc_pkg::COLOR_W-1:0];
      out_max_r    <= highest_kw[gc_pkg::COLOR_W-1:0];
      out_ovf_r    <= !found;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex       = out_vertex_r;
  assign out_vertex_color = out_color_r;
  assign out_max_color    = out_max_r;
  assign out_overflow     = out_ovf_r;

`ifndef NO_ASSERTIONS
  // overflowed vertices are always given color 0
  a_ovf_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_vertex_color == '0))
    else $error("overflow result with nonzero color");

  // back-pressure only comes from a closing entry blocked by a full result register
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("in_ready low without a blocked closing entry");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a write to the store always comes with a new result
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid)
    else $error("store write without result");
`endif

endmodule : greedy_graph_coloring

`default_nettype wire
